// ----- src/huffman_code_bit_packer_top_assert.svh -----
// assertion macros for the huffman code bit packer
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define HCBP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcbp assertion failed");

// consequent must hold in the cycle after the antecedent
`define HCBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcbp assertion failed");

`endif

// ----- src/hcbp_pkg.sv -----
// package: commands, table port types and helpers for the huffman code bit packer
package hcbp_pkg;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_ENCODE = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;

	typedef struct packed {
		logic        wr_en;
		logic        rd_en;
		logic [7:0]  addr;
		logic [31:0] value;
		logic [5:0]  len;
	} tbl_req_t;

	typedef struct packed {
		logic [31:0] value;
		logic [5:0]  len;
	} tbl_rsp_t;

	// right-align the top rem bits of a left-aligned byte
	function automatic logic [6:0] hcbp_align(input logic [7:0] top, input logic [2:0] rem);
		logic [7:0] sh;
		sh = top >> (4'd8 - {1'b0, rem});
		return sh[6:0];
	endfunction

endpackage

// ----- src/hcbp_table.sv -----
// code table memory with per-entry valid bits
module hcbp_table import hcbp_pkg::*; #(
	parameter int CAP = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_req_t req,
	output tbl_rsp_t rsp
);

	localparam int LEN_W = $clog2(CAP + 1);
	localparam int ENT_W = CAP + LEN_W;

	logic [ENT_W-1:0] mem [256];
	logic [255:0]     vld_q;
	logic [ENT_W-1:0] ent_q;
	logic             hit_q;
	logic [LEN_W-1:0] len_c;
	logic [CAP-1:0]   mask;
	logic [CAP-1:0]   wval;

	always_comb begin
		len_c = (req.len > 6'(CAP)) ? LEN_W'(CAP) : LEN_W'(req.len);
		mask  = ~({CAP{1'b1}} << len_c);
		wval  = req.value[CAP-1:0] & mask;
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= {len_c, wval};
		end
		if (req.rd_en) begin
			ent_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				hit_q <= vld_q[req.addr];
			end
		end
	end

	assign rsp.value = hit_q ? 32'(ent_q[CAP-1:0]) : 32'd0;
	assign rsp.len   = hit_q ? 6'(ent_q[ENT_W-1:CAP]) : 6'd0;

endmodule

// ----- src/hcbp_packer.sv -----
// command sequencer, bit merge, byte emitter and output register
`include "huffman_code_bit_packer_top_assert.svh"

module hcbp_packer import hcbp_pkg::*; #(
	parameter int CAP = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  symbol,
	input  logic [31:0] code_value,
	input  logic [5:0]  code_length,
	output tbl_req_t    tbl_req,
	input  tbl_rsp_t    tbl_rsp,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  packed_byte,
	output logic        last_of_run,
	output logic [31:0] bytes_emitted
);

	localparam int BUF_W = CAP + 8;
	localparam int SH_W  = $clog2(BUF_W + 1);
	localparam int MAXB  = (CAP + 7) / 8;
	localparam int CNT_W = $clog2(MAXB + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [BUF_W-1:0] buf_q;
	logic [CNT_W-1:0] left_q;
	logic [2:0]       rem_q;
	logic [6:0]       partial_q;
	logic [2:0]       pend_q;
	logic [31:0]      cnt_q;
	logic             bv_q;
	logic [7:0]       pb_q;
	logic             last_q;

	logic             accept;
	logic             out_free;
	logic             load_out;
	logic [SH_W-1:0]  len_s;
	logic [SH_W-1:0]  pend_s;
	logic [SH_W-1:0]  total;
	logic [BUF_W-1:0] p_al;
	logic [BUF_W-1:0] v_al;
	logic [BUF_W-1:0] w;
	logic [CNT_W-1:0] nb;
	logic [2:0]       rem;
	logic [31:0]      cnt_nx;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !bv_q || !byte_stall;
	assign load_out  = (state_q == ST_EMIT) && out_free;

	always_comb begin
		tbl_req.wr_en = accept && (command == CMD_LOAD);
		tbl_req.rd_en = accept && (command == CMD_ENCODE);
		tbl_req.addr  = symbol;
		tbl_req.value = code_value;
		tbl_req.len   = code_length;
	end

	// merge pending bits and the looked-up code, left aligned
	always_comb begin
		len_s  = SH_W'(tbl_rsp.len);
		pend_s = SH_W'(pend_q);
		p_al   = BUF_W'(partial_q) << (SH_W'(BUF_W) - pend_s);
		v_al   = (BUF_W'(tbl_rsp.value[CAP-1:0]) << (SH_W'(BUF_W) - len_s)) >> pend_s;
		w      = p_al | v_al;
		total  = pend_s + len_s;
		nb     = CNT_W'(total >> 3);
		rem    = total[2:0];
		cnt_nx = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			partial_q <= '0;
			pend_q    <= '0;
			cnt_q     <= '0;
			bv_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_ENCODE) begin
							state_q <= ST_LOOK;
						end else if (command == CMD_FLUSH && pend_q != 3'd0) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_LOOK: begin
					if (nb == '0) begin
						partial_q <= hcbp_align(w[BUF_W-1 -: 8], rem);
						pend_q    <= rem;
						state_q   <= ST_IDLE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_nx;
						if (left_q == CNT_W'(1)) begin
							partial_q <= hcbp_align(buf_q[BUF_W-9 -: 8], rem_q);
							pend_q    <= rem_q;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				bv_q <= 1'b1;
			end else if (!byte_stall) begin
				bv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_FLUSH) begin
			buf_q  <= p_al;
			left_q <= CNT_W'(1);
			rem_q  <= 3'd0;
		end else if (state_q == ST_LOOK) begin
			buf_q  <= w;
			left_q <= nb;
			rem_q  <= rem;
		end else if (load_out) begin
			pb_q   <= buf_q[BUF_W-1 -: 8];
			last_q <= (left_q == CNT_W'(1));
			buf_q  <= buf_q << 8;
			left_q <= left_q - CNT_W'(1);
		end
	end

	assign byte_valid    = bv_q;
	assign packed_byte   = pb_q;
	assign last_of_run   = last_q;
	assign bytes_emitted = cnt_q;

	`HCBP_ASSERT_NEXT(a_look_after_encode, accept && command == CMD_ENCODE, state_q == ST_LOOK)
	`HCBP_ASSERT_NOW(a_emit_left, state_q == ST_EMIT, left_q != '0 && left_q <= CNT_W'(MAXB))
	`HCBP_ASSERT_NOW(a_rsp_len_cap, state_q == ST_LOOK, tbl_rsp.len <= 6'(CAP))
	`HCBP_ASSERT_NEXT(a_cnt_step, load_out && cnt_q != 32'hFFFF_FFFF, cnt_q == $past(cnt_q) + 32'd1)

endmodule

// ----- src/huffman_code_bit_packer_top.sv -----
// top level of the huffman code bit packer
//
//  channel   handshake              payload
//  request   req_valid/req_stall    command, symbol, code_value, code_length
//  output    byte_valid/byte_stall  packed_byte, last_of_run, bytes_emitted
//
// load and flush-with-nothing-pending complete without leaving idle; encode reads the
// table, merges the bits, then emits each finished byte (0 to 4) through the single
// byte output register; flush with pending bits emits one zero-padded byte.
// reset clears the table valid bits, the pending bits and the byte count at once.
// a stall on the output holds the emitter and with it the request side.
module huffman_code_bit_packer_top import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  symbol,
	input  logic [31:0] code_value,
	input  logic [5:0]  code_length,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  packed_byte,
	output logic        last_of_run,
	output logic [31:0] bytes_emitted
);

	localparam int CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

	tbl_req_t tbl_req;
	tbl_rsp_t tbl_rsp;

	hcbp_table #(
		.CAP(CAP)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (tbl_req),
		.rsp   (tbl_rsp)
	);

	hcbp_packer #(
		.CAP(CAP)
	) u_packer (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.command      (command),
		.symbol       (symbol),
		.code_value   (code_value),
		.code_length  (code_length),
		.tbl_req      (tbl_req),
		.tbl_rsp      (tbl_rsp),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.packed_byte  (packed_byte),
		.last_of_run  (last_of_run),
		.bytes_emitted(bytes_emitted)
	);

endmodule

// ----- bench/huffman_code_bit_packer_top_tb.sv -----
// self-checking bench for the huffman code bit packer: directed table, then random requests
`timescale 1ns / 100ps

module huffman_code_bit_packer_top_tb import hcbp_pkg::*; ();

	localparam int CODE_LEN_MAX = 32;
	localparam int LEN_CAP = (CODE_LEN_MAX < 32) ? CODE_LEN_MAX : 32;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int N_DIRECTED = 26;
	localparam int N_RANDOM = 255;
	localparam int CALM_FROM = 215;
	localparam int DRAIN_AT = 100;
	localparam int POOL_SIZE = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [31:0] count;
	} packed_out_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  sym;
		logic [31:0] val;
		logic [5:0]  len;
		logic        typed;
		logic        has_out;
		logic [7:0]  t_data;
		logic [31:0] t_count;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  command = CMD_LOAD;
	logic [7:0]  symbol = 8'h00;
	logic [31:0] code_value = 32'h0;
	logic [5:0]  code_length = 6'd0;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  packed_byte;
	logic        last_of_run;
	logic [31:0] bytes_emitted;

	logic [31:0] code_val_mem [256];
	logic [5:0]  code_len_mem [256];
	logic [6:0]  bit_acc;
	int          bit_cnt;
	logic [31:0] emit_total;

	packed_out_t expected_bytes [$];
	dir_row_t    dir_rows [N_DIRECTED];
	logic [7:0]  sym_pool [POOL_SIZE];

	int  n_errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_encodes = 0;
	int  n_flushes = 0;
	int  n_loads = 0;
	bit  calm = 1'b0;

	huffman_code_bit_packer_top #(
		.MAX_CODE_LEN(CODE_LEN_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.command(command),
		.symbol(symbol),
		.code_value(code_value),
		.code_length(code_length),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.packed_byte(packed_byte),
		.last_of_run(last_of_run),
		.bytes_emitted(bytes_emitted)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// expected bytes for one request; keep = 0 only updates the state
	task automatic pack_request(input logic [1:0] cmd, input logic [7:0] sym,
			input logic [31:0] val, input logic [5:0] len, input bit keep);
		packed_out_t outs [$];
		packed_out_t o;
		logic [5:0]  l;
		logic [63:0] mask;
		logic [7:0]  acc;
		int          j;
		case (cmd)
			CMD_LOAD: begin
				l = (len > LEN_CAP) ? 6'(LEN_CAP) : len;
				mask = (64'h1 << l) - 64'h1;
				code_val_mem[sym] = val & mask[31:0];
				code_len_mem[sym] = l;
			end
			CMD_ENCODE: begin
				for (j = int'(code_len_mem[sym]) - 1; j >= 0; j--) begin
					acc = {bit_acc, code_val_mem[sym][j]};
					bit_cnt++;
					if (bit_cnt == 8) begin
						if (emit_total != 32'hFFFF_FFFF)
							emit_total++;
						o.data = acc;
						o.last = 1'b0;
						o.count = emit_total;
						outs.insert(outs.size(), o);
						bit_acc = 7'd0;
						bit_cnt = 0;
					end else begin
						bit_acc = acc[6:0];
					end
				end
			end
			CMD_FLUSH: begin
				if (bit_cnt != 0) begin
					if (emit_total != 32'hFFFF_FFFF)
						emit_total++;
					acc = 8'({1'b0, bit_acc} << (8 - bit_cnt));
					o.data = acc;
					o.last = 1'b0;
					o.count = emit_total;
					outs.insert(outs.size(), o);
					bit_acc = 7'd0;
					bit_cnt = 0;
				end
			end
			default: begin
			end
		endcase
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		if (keep)
			foreach (outs[k]) expected_bytes.insert(expected_bytes.size(), outs[k]);
	endtask

	task automatic send_req(input logic [1:0] c, input logic [7:0] s,
			input logic [31:0] v, input logic [5:0] l);
		command <= c;
		symbol <= s;
		code_value <= v;
		code_length <= l;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		n_sent++;
		case (c)
			CMD_LOAD: n_loads++;
			CMD_ENCODE: n_encodes++;
			CMD_FLUSH: n_flushes++;
			default: begin
			end
		endcase
	endtask

	task automatic pause_sender(input int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// output stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (!calm && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 18);
			byte_stall <= (stall_left > 0);
		end
	end

	always @(posedge clk) begin
		packed_out_t e;
		if (arst_n && byte_valid && !byte_stall) begin
			if (expected_bytes.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected byte, expected none, actual %h last %b count %0d",
					$time, packed_byte, last_of_run, bytes_emitted);
			end else begin
				e = expected_bytes.pop_front();
				n_checked++;
				if (packed_byte !== e.data) begin
					n_errors++;
					$display("%0t: packed_byte expected %h actual %h",
						$time, e.data, packed_byte);
				end
				if (last_of_run !== e.last) begin
					n_errors++;
					$display("%0t: last_of_run expected %b actual %b",
						$time, e.last, last_of_run);
				end
				if (bytes_emitted !== e.count) begin
					n_errors++;
					$display("%0t: bytes_emitted expected %0d actual %0d",
						$time, e.count, bytes_emitted);
				end
			end
		end
	end

	initial begin
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("timeout after %0d cycles, %0d bytes still expected",
			cyc, expected_bytes.size());
		$display("huffman_code_bit_packer_top_tb: done, errors");
		$finish;
	end

	initial begin
		int          i;
		int          r;
		int          p;
		logic [1:0]  c;
		logic [7:0]  s;
		logic [31:0] v;
		logic [5:0]  l;
		packed_out_t t;

		for (i = 0; i < 256; i++) begin
			code_val_mem[i] = 32'h0;
			code_len_mem[i] = 6'd0;
		end
		bit_acc = 7'd0;
		bit_cnt = 0;
		emit_total = 32'd0;
		for (i = 0; i < POOL_SIZE; i++)
			sym_pool[i] = 8'($urandom);

		dir_rows[0]  = '{CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[1]  = '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[2]  = '{CMD_NONE,   8'h55, 32'h0000_1234, 6'd5,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[3]  = '{CMD_LOAD,   8'h41, 32'hFFFF_FF5A, 6'd8,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[4]  = '{CMD_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1'b1, 1'b1, 8'h5A, 32'd1};
		dir_rows[5]  = '{CMD_LOAD,   8'h00, 32'h0000_0001, 6'd1,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[6]  = '{CMD_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[7]  = '{CMD_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 8'h80, 32'd2};
		dir_rows[8]  = '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[9]  = '{CMD_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[10] = '{CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 32'd0};
		dir_rows[11] = '{CMD_LOAD,   8'h80, 32'hA5A5_A5A5, 6'd32, 1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[12] = '{CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[13] = '{CMD_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 32'd0};
		dir_rows[14] = '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 32'd0};
		dir_rows[15] = '{CMD_LOAD,   8'h7F, 32'h0000_0000, 6'd32, 1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[16] = '{CMD_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 32'd0};
		dir_rows[17] = '{CMD_LOAD,   8'h41, 32'h0000_FFFF, 6'd0,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[18] = '{CMD_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[19] = '{CMD_LOAD,   8'h10, 32'hFFFF_FFFD, 6'd3,  1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[20] = '{CMD_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 32'd0};
		dir_rows[21] = '{CMD_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 32'd0};
		dir_rows[22] = '{CMD_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 32'd0};
		dir_rows[23] = '{CMD_LOAD,   8'h20, 32'h0000_003F, 6'd40, 1'b1, 1'b0, 8'h00, 32'd0};
		dir_rows[24] = '{CMD_ENCODE, 8'h20, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 32'd0};
		dir_rows[25] = '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 32'd0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			pack_request(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].val, dir_rows[i].len,
				!dir_rows[i].typed);
			if (dir_rows[i].typed && dir_rows[i].has_out) begin
				t.data = dir_rows[i].t_data;
				t.last = 1'b1;
				t.count = dir_rows[i].t_count;
				expected_bytes.insert(expected_bytes.size(), t);
			end
			if ($urandom_range(0, 4) == 0)
				pause_sender($urandom_range(1, 18));
			send_req(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].val, dir_rows[i].len);
		end

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == CALM_FROM)
				calm = 1'b1;
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				s = 8'($urandom);
			else
				s = sym_pool[$urandom_range(0, POOL_SIZE - 1)];
			v = $urandom;
			l = 6'($urandom);
			if (r < 25) begin
				c = CMD_LOAD;
				p = $urandom_range(0, 19);
				if (p < 12)
					l = 6'($urandom_range(1, 10));
				else if (p < 17)
					l = 6'($urandom_range(11, 32));
				else if (p < 18)
					l = 6'd0;
				else
					l = 6'($urandom_range(33, 63));
			end else if (r < 80) begin
				c = CMD_ENCODE;
			end else if (r < 94) begin
				c = CMD_FLUSH;
			end else begin
				c = CMD_NONE;
			end
			if (i == DRAIN_AT) begin
				req_valid <= 1'b0;
				while (expected_bytes.size() != 0) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				pause_sender($urandom_range(1, 18));
			end
			pack_request(c, s, v, l, 1'b1);
			send_req(c, s, v, l);
		end

		req_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d requests (%0d loads, %0d encodes, %0d flushes), checked %0d bytes",
			n_sent, n_loads, n_encodes, n_flushes, n_checked);
		$display("idle and stall bursts on both sides, one full drain, calm tail; %0d mismatches",
			n_errors);
		if (n_errors == 0) begin
			$display("huffman_code_bit_packer_top_tb: done, clean");
		end else begin
			$display("huffman_code_bit_packer_top_tb: done, errors");
		end
		$finish;
	end

endmodule
